FILE: rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and defaults for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SlotsDef      = 16;
  localparam int PeriodBitsDef = 24;
  // expirations reported per tick at most; further ones are only reloaded
  localparam int MaxResults    = 16;
  localparam int ResCntW       = $clog2(MaxResults + 1);

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // response kinds
  localparam logic [1:0] RSP_ADD_ACK    = 2'd0;
  localparam logic [1:0] RSP_REMOVE_ACK = 2'd1;
  localparam logic [1:0] RSP_EXPIRED    = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] period_ms;
    logic [4:0]  target_handle;
  } req_t;

  typedef struct packed {
    logic [1:0] resp_kind;
    logic [4:0] result_handle;
    logic [1:0] status;
    logic       last;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_TICK
  } cmd_e;

  // control part of a queued command
  typedef struct packed {
    cmd_e       kind;
    logic       tgt_ok;
    logic [4:0] tgt_handle;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EMIT,
    ST_TICK,
    ST_FLUSH
  } back_state_e;

endpackage

FILE: rtl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers with add, remove and tick requests.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   -------   -----------------------   ---------------------------------
//   request   in_valid_i / in_ready_o   in_req_i   (req_type, period_ms,
//                                                  target_handle)
//   result    out_valid_o / out_ready_i out_rsp_o  (resp_kind, result_handle,
//                                                  status, last)
//
// Requests enter a two-entry command queue; the executor runs one at a time.
// Remove answers directly; add probes one slot per cycle from the allocation hint.
// Tick sweeps every slot through the single read port of the slot memory.
// A stalled result transfer holds the executor; the queue takes requests until full.
// Reset clears all timers and sets the allocation hint to handle 1.
module periodic_timer_table #(
  parameter int SLOTS       = ptt_pkg::SlotsDef,
  parameter int PERIOD_BITS = ptt_pkg::PeriodBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ptt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ptt_pkg::rsp_t out_rsp_o
);

  logic                   cmd_valid;
  logic                   cmd_ready;
  ptt_pkg::cmd_ctl_t      cmd_ctl;
  logic [PERIOD_BITS-1:0] cmd_period;

  ptt_front #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_ctl_o    (cmd_ctl),
    .cmd_period_o (cmd_period)
  );

  ptt_back #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_ctl_i    (cmd_ctl),
    .cmd_period_i (cmd_period),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

FILE: rtl/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front
// Request intake: classifies each transfer and queues the known ones for the back end.
// ----------------------------------------------------------------------------
module ptt_front #(
  parameter int SLOTS       = ptt_pkg::SlotsDef,
  parameter int PERIOD_BITS = ptt_pkg::PeriodBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ptt_pkg::req_t           in_req_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output ptt_pkg::cmd_ctl_t       cmd_ctl_o,
  output logic [PERIOD_BITS-1:0]  cmd_period_o
);

  localparam int Depth = 2;

  ptt_pkg::cmd_ctl_t      ctl_q [Depth];
  logic [PERIOD_BITS-1:0] per_q [Depth];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;

  ptt_pkg::cmd_ctl_t      new_ctl;
  logic [PERIOD_BITS-1:0] new_per;
  logic [PERIOD_BITS-1:0] per_masked;
  logic                   known;
  logic                   push, pop;

  // classify
  always_comb begin
    known        = 1'b1;
    new_ctl.kind = ptt_pkg::CMD_TICK;
    case (in_req_i.req_type)
      ptt_pkg::REQ_ADD:    new_ctl.kind = ptt_pkg::CMD_ADD;
      ptt_pkg::REQ_REMOVE: new_ctl.kind = ptt_pkg::CMD_REMOVE;
      ptt_pkg::REQ_TICK:   new_ctl.kind = ptt_pkg::CMD_TICK;
      default:             known        = 1'b0;  // dropped silently
    endcase
    new_ctl.tgt_handle = in_req_i.target_handle;
    new_ctl.tgt_ok     = (in_req_i.target_handle != 5'd0) &&
                         (32'(in_req_i.target_handle) <= SLOTS);
    per_masked = PERIOD_BITS'(in_req_i.period_ms);
    new_per    = (per_masked == '0) ? PERIOD_BITS'(1) : per_masked;
  end

  assign in_ready_o   = (cnt_q != 2'(Depth));
  assign push         = in_valid_i && in_ready_o && known;
  assign cmd_valid_o  = (cnt_q != 2'd0);
  assign pop          = cmd_valid_o && cmd_ready_i;
  assign cmd_ctl_o    = ctl_q[rd_ptr_q];
  assign cmd_period_o = per_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q] <= new_ctl;
      per_q[wr_ptr_q] <= new_per;
    end
  end

endmodule

FILE: rtl/ptt_back.sv
// ----------------------------------------------------------------------------
// ptt_back
// Command executor: slot table, allocation scan, tick sweep, result register.
// ----------------------------------------------------------------------------
module ptt_back #(
  parameter int SLOTS       = ptt_pkg::SlotsDef,
  parameter int PERIOD_BITS = ptt_pkg::PeriodBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  ptt_pkg::cmd_ctl_t       cmd_ctl_i,
  input  logic [PERIOD_BITS-1:0]  cmd_period_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ptt_pkg::rsp_t           out_rsp_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int PW   = PERIOD_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  function automatic logic [4:0] to_handle(input logic [IdxW-1:0] idx);
    logic [CntW-1:0] h;
    h = CntW'(idx) + CntW'(1);
    return 5'(h);
  endfunction

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  // slot memory: {period, remaining}
  logic [2*PW-1:0] mem_q [SLOTS];
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [2*PW-1:0] mem_wd;
  logic            rd_en;
  logic [2*PW-1:0] rdata_q;

  ptt_pkg::back_state_e state_q, state_d;
  logic [SLOTS-1:0]        armed_q, armed_d;
  logic [IdxW-1:0]         hint_q, hint_d;
  logic [IdxW-1:0]         scan_q, scan_d;
  logic [IdxW-1:0]         nscan_q, nscan_d;
  logic [PW-1:0]           period_q, period_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    issue_done_q, issue_done_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]         rd_idx_q, rd_idx_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;
  logic [ptt_pkg::ResCntW-1:0] cnt_q, cnt_d;
  ptt_pkg::rsp_t           res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  ptt_pkg::rsp_t           out_q, out_d;

  logic            out_free;
  logic [4:0]      tgt_m1;
  logic [IdxW-1:0] tgt_idx;
  logic [PW-1:0]   rem, per;
  logic            armed_hit, expire, report, stall;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ptt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign tgt_m1      = cmd_ctl_i.tgt_handle - 5'd1;
  assign tgt_idx     = IdxW'(tgt_m1);

  assign rem       = rdata_q[PW-1:0];
  assign per       = rdata_q[2*PW-1:PW];
  assign armed_hit = rd_vld_q && armed_q[rd_idx_q];
  assign expire    = armed_hit && (rem <= PW'(1));
  assign report    = expire && (cnt_q < ptt_pkg::ResCntW'(ptt_pkg::MaxResults));
  // an earlier expiry is held back until the next one shows whether it is last
  assign stall     = report && pend_vld_q && !out_free;

  always_comb begin
    state_d      = state_q;
    armed_d      = armed_q;
    hint_d       = hint_q;
    scan_d       = scan_q;
    nscan_d      = nscan_q;
    period_d     = period_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = rd_vld_q;
    rd_idx_d     = rd_idx_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    cnt_d        = cnt_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_wa       = scan_q;
    mem_wd       = {period_q, period_q};
    rd_en        = 1'b0;

    case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_ctl_i.kind)
            ptt_pkg::CMD_ADD: begin
              scan_d   = hint_q;
              nscan_d  = '0;
              period_d = cmd_period_i;
              state_d  = ptt_pkg::ST_ADD;
            end
            ptt_pkg::CMD_REMOVE: begin
              if (cmd_ctl_i.tgt_ok && armed_q[tgt_idx]) begin
                armed_d[tgt_idx] = 1'b0;
                res_d = '{ptt_pkg::RSP_REMOVE_ACK, cmd_ctl_i.tgt_handle,
                          ptt_pkg::STAT_OK, 1'b1};
              end else begin
                res_d = '{ptt_pkg::RSP_REMOVE_ACK, 5'd0,
                          ptt_pkg::STAT_UNKNOWN, 1'b1};
              end
              state_d = ptt_pkg::ST_EMIT;
            end
            ptt_pkg::CMD_TICK: begin
              idx_d        = '0;
              issue_done_d = 1'b0;
              rd_vld_d     = 1'b0;
              pend_vld_d   = 1'b0;
              cnt_d        = '0;
              state_d      = ptt_pkg::ST_TICK;
            end
            default: state_d = ptt_pkg::ST_IDLE;
          endcase
        end
      end

      ptt_pkg::ST_ADD: begin
        // probe one slot per cycle, circularly from the hint
        if (!armed_q[scan_q]) begin
          armed_d[scan_q] = 1'b1;
          mem_we  = 1'b1;
          hint_d  = next_idx(scan_q);
          res_d   = '{ptt_pkg::RSP_ADD_ACK, to_handle(scan_q), ptt_pkg::STAT_OK, 1'b1};
          state_d = ptt_pkg::ST_EMIT;
        end else if (nscan_q == LastIdx) begin
          res_d   = '{ptt_pkg::RSP_ADD_ACK, 5'd0, ptt_pkg::STAT_FULL, 1'b1};
          state_d = ptt_pkg::ST_EMIT;
        end else begin
          scan_d  = next_idx(scan_q);
          nscan_d = nscan_q + IdxW'(1);
        end
      end

      ptt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ptt_pkg::ST_IDLE;
        end
      end

      ptt_pkg::ST_TICK: begin
        // read slot idx_q while updating slot rd_idx_q
        if (!stall) begin
          rd_en = 1'b1;
          if (armed_hit) begin
            mem_we = 1'b1;
            mem_wa = rd_idx_q;
            mem_wd = {per, expire ? per : rem - PW'(1)};
          end
          if (report) begin
            if (pend_vld_q) begin
              out_valid_d = 1'b1;
              out_d = '{ptt_pkg::RSP_EXPIRED, to_handle(pend_idx_q), ptt_pkg::STAT_OK, 1'b0};
            end
            pend_vld_d = 1'b1;
            pend_idx_d = rd_idx_q;
            cnt_d      = cnt_q + ptt_pkg::ResCntW'(1);
          end
          rd_vld_d = !issue_done_q;
          rd_idx_d = idx_q;
          if (!issue_done_q) begin
            if (idx_q == LastIdx) begin
              issue_done_d = 1'b1;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          if (rd_vld_q && (rd_idx_q == LastIdx)) begin
            state_d = ptt_pkg::ST_FLUSH;
          end
        end
      end

      ptt_pkg::ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ptt_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{ptt_pkg::RSP_EXPIRED, to_handle(pend_idx_q), ptt_pkg::STAT_OK, 1'b1};
          pend_vld_d  = 1'b0;
          state_d     = ptt_pkg::ST_IDLE;
        end
      end

      default: state_d = ptt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptt_pkg::ST_IDLE;
      armed_q      <= '0;
      hint_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      pend_vld_q   <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      armed_q      <= armed_d;
      hint_q       <= hint_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      pend_vld_q   <= pend_vld_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    nscan_q    <= nscan_d;
    period_q   <= period_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

endmodule

FILE: tb/sv/periodic_timer_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_table_tb
// Self-checking bench for the periodic timer table. A scoreboard keeps its
// own copy of the timer slots and the allocation hint, predicts the response
// stream of every accepted request and checks each result transfer in order.
// Directed requests cover empty and full tables, unknown handles, zero and
// maximum periods, the ignored request code and a tick where every slot
// expires. Random traffic follows under three handshake idling profiles.
// ----------------------------------------------------------------------------

class ptt_scoreboard;

  bit            armed     [ptt_pkg::SlotsDef];
  logic [23:0]   period_q  [ptt_pkg::SlotsDef];
  logic [23:0]   countdown [ptt_pkg::SlotsDef];
  logic [4:0]    next_hint;
  ptt_pkg::rsp_t expected_rsps [$];

  int mismatches;
  int n_add, n_full, n_remove, n_unknown, n_tick, n_ignored, n_expired;

  function new();
    foreach (armed[i]) armed[i] = 1'b0;
    next_hint = 5'd1;
  endfunction

  function ptt_pkg::rsp_t make_rsp(logic [1:0] kind, logic [4:0] handle, logic [1:0] stat,
                                   logic is_last);
    ptt_pkg::rsp_t r;
    r.resp_kind     = kind;
    r.result_handle = handle;
    r.status        = stat;
    r.last          = is_last;
    return r;
  endfunction

  function void expect_rsp(ptt_pkg::rsp_t r);
    expected_rsps = {expected_rsps, r};
  endfunction

  function logic [4:0] next_handle(logic [4:0] h);
    return (h >= 5'(ptt_pkg::SlotsDef)) ? 5'd1 : h + 5'd1;
  endfunction

  function int pending();
    return expected_rsps.size();
  endfunction

  // update the slot table for one accepted request and queue its responses
  function void note_request(ptt_pkg::req_t r);
    logic [23:0]   p;
    logic [4:0]    h;
    bit            placed;
    int            fired;
    ptt_pkg::rsp_t tail;
    case (r.req_type)
      ptt_pkg::REQ_ADD: begin
        n_add++;
        p = (r.period_ms == '0) ? 24'd1 : r.period_ms;
        h = (next_hint < 5'd1 || next_hint > 5'(ptt_pkg::SlotsDef)) ? 5'd1 : next_hint;
        placed = 1'b0;
        for (int n = 0; n < ptt_pkg::SlotsDef; n++) begin
          if (!placed) begin
            if (!armed[h - 1]) begin
              armed[h - 1]     = 1'b1;
              period_q[h - 1]  = p;
              countdown[h - 1] = p;
              next_hint        = next_handle(h);
              placed           = 1'b1;
            end else begin
              h = next_handle(h);
            end
          end
        end
        if (placed) begin
          expect_rsp(make_rsp(ptt_pkg::RSP_ADD_ACK, h, ptt_pkg::STAT_OK, 1'b1));
        end else begin
          n_full++;
          expect_rsp(make_rsp(ptt_pkg::RSP_ADD_ACK, 5'd0, ptt_pkg::STAT_FULL, 1'b1));
        end
      end
      ptt_pkg::REQ_REMOVE: begin
        n_remove++;
        h = r.target_handle;
        if (h >= 5'd1 && h <= 5'(ptt_pkg::SlotsDef) && armed[h - 1]) begin
          armed[h - 1] = 1'b0;
          expect_rsp(make_rsp(ptt_pkg::RSP_REMOVE_ACK, h, ptt_pkg::STAT_OK, 1'b1));
        end else begin
          n_unknown++;
          expect_rsp(make_rsp(ptt_pkg::RSP_REMOVE_ACK, 5'd0, ptt_pkg::STAT_UNKNOWN,
                              1'b1));
        end
      end
      ptt_pkg::REQ_TICK: begin
        n_tick++;
        fired = 0;
        for (int i = 0; i < ptt_pkg::SlotsDef; i++) begin
          if (armed[i]) begin
            if (countdown[i] <= 24'd1) begin
              countdown[i] = period_q[i];
              // overflow beyond the report limit is reloaded silently
              if (fired < ptt_pkg::MaxResults) begin
                expect_rsp(make_rsp(ptt_pkg::RSP_EXPIRED, 5'(i + 1), ptt_pkg::STAT_OK,
                                    1'b0));
                fired++;
              end
            end else begin
              countdown[i] = countdown[i] - 24'd1;
            end
          end
        end
        n_expired += fired;
        if (fired > 0) begin
          tail      = expected_rsps.pop_back();
          tail.last = 1'b1;
          expect_rsp(tail);
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_response(ptt_pkg::rsp_t got);
    ptt_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d handle=%0d status=%0d last=%0d",
                                got.resp_kind, got.result_handle, got.status, got.last));
    end else begin
      want = expected_rsps.pop_front();
      if (got.resp_kind !== want.resp_kind)
        report_mismatch($sformatf("resp_kind %0d, wanted %0d", got.resp_kind,
                                  want.resp_kind));
      if (got.result_handle !== want.result_handle)
        report_mismatch($sformatf("result_handle %0d, wanted %0d", got.result_handle,
                                  want.result_handle));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, wanted %0d", got.last, want.last));
    end
  endtask

endclass

module periodic_timer_table_tb;

  localparam int          RandomItems = 500;
  localparam int          CycleLimit  = 1_000_000;
  localparam int          DrainCycles = 8 * (ptt_pkg::SlotsDef + 3);
  localparam logic [1:0]  REQ_RESERVED = 2'd3;

  logic          clk      = 1'b0;
  logic          rst_n    = 1'b0;
  logic          in_valid = 1'b0;
  ptt_pkg::req_t in_req   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  ptt_pkg::rsp_t out_rsp_o;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int cycles       = 0;

  ptt_scoreboard sb;

  periodic_timer_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // inputs only change at rising edges, so the middle of the cycle is stable
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_request(in_req);
      if (out_valid_o && out_ready) sb.check_response(out_rsp_o);
    end
  end

  function automatic ptt_pkg::req_t build_request(logic [1:0] kind, logic [23:0] period,
                                                  logic [4:0] handle);
    ptt_pkg::req_t r;
    r.req_type      = kind;
    r.period_ms     = period;
    r.target_handle = handle;
    return r;
  endfunction

  function automatic ptt_pkg::req_t random_request();
    int          pick;
    logic [1:0]  kind;
    logic [23:0] period;
    logic [4:0]  handle;
    pick   = $urandom_range(99);
    kind   = (pick < 40) ? ptt_pkg::REQ_ADD : (pick < 65) ? ptt_pkg::REQ_REMOVE :
             (pick < 95) ? ptt_pkg::REQ_TICK : REQ_RESERVED;
    // short periods keep ticks producing expirations
    period = ($urandom_range(99) < 80) ? 24'($urandom_range(0, 6)) : 24'($urandom());
    handle = ($urandom_range(99) < 85) ? 5'($urandom_range(1, ptt_pkg::SlotsDef)) :
             5'($urandom_range(0, 31));
    return build_request(kind, period, handle);
  endfunction

  task automatic send_request(input ptt_pkg::req_t r);
    logic taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do begin
      @(negedge clk);
      taken = in_ready_o;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin
    int            counted;
    ptt_pkg::req_t r;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 35;
    out_idle_pct = 79;

    // empty table: unknown handles, a quiet tick, the ignored code
    send_request(build_request(ptt_pkg::REQ_REMOVE, 24'hABCDEF, 5'd0));
    send_request(build_request(ptt_pkg::REQ_REMOVE, 24'h000000, 5'd31));
    send_request(build_request(ptt_pkg::REQ_REMOVE, 24'h123456, 5'd5));
    send_request(build_request(ptt_pkg::REQ_TICK, 24'hFFFFFF, 5'd31));
    send_request(build_request(REQ_RESERVED, 24'h000001, 5'd1));
    // fill the table: zero period, maximum period, then period two
    send_request(build_request(ptt_pkg::REQ_ADD, 24'h000000, 5'd0));
    send_request(build_request(ptt_pkg::REQ_ADD, 24'hFFFFFF, 5'd31));
    for (int i = 3; i <= ptt_pkg::SlotsDef; i++) begin
      send_request(build_request(ptt_pkg::REQ_ADD, 24'd2, 5'(i)));
    end
    send_request(build_request(ptt_pkg::REQ_ADD, 24'd3, 5'd0));
    send_request(build_request(ptt_pkg::REQ_TICK, 24'd0, 5'd0));
    // swap the long timer for a fast one, then every slot fires at once
    send_request(build_request(ptt_pkg::REQ_REMOVE, 24'd0, 5'd2));
    send_request(build_request(ptt_pkg::REQ_ADD, 24'd1, 5'd0));
    send_request(build_request(ptt_pkg::REQ_TICK, 24'd0, 5'd0));

    counted = 0;
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 35 : (ph == 1) ? 79 : 0;
      out_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 35 : 0;
      while (counted < (ph + 1) * RandomItems / 3) begin
        r = random_request();
        send_request(r);
        if (r.req_type != REQ_RESERVED) counted++;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("requests: %0d add (%0d table full), %0d remove (%0d unknown),",
             sb.n_add, sb.n_full, sb.n_remove, sb.n_unknown);
    $display("  %0d tick, %0d ignored; expirations checked: %0d, mismatches: %0d, cycles: %0d",
             sb.n_tick, sb.n_ignored, sb.n_expired, sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
